>>> rtl/ffsot_pkg.sv
`default_nettype none
package ffsot_pkg;

	// sizing
	localparam int SLOTS   = 64;
	localparam int ID_BITS = 16;

	// fixed port widths
	localparam int KIND_W  = 2;
	localparam int CID_W   = 16;
	localparam int SEAT_W  = 7;
	localparam int STAT_W  = 3;
	localparam int CAP_W   = 7;
	localparam int COUNT_W = 7;

	localparam int ID_W   = (ID_BITS < CID_W) ? ID_BITS : CID_W;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int CMP_W  = (CNT_W > SEAT_W) ? CNT_W : SEAT_W;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_FREE  = 3'd1,
		ST_RANGE    = 3'd2,
		ST_ALR_FREE = 3'd3,
		ST_ID_ZERO  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_RESERVE = 2'd1,
		OP_RELEASE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	// classified command, front to back
	typedef struct packed {
		op_t              op;
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [IDX_W-1:0] idx;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/first_free_slot_owner_table_core.sv
`default_nettype none
// channel   handshake              word
// in        in_valid / in_ready    kind, client_id, seat
// out       out_valid / out_ready  status, seat_number, owner_id, free_count,
//                                  occupied_count
// cfg       cfg_write (no wait)    cfg_data = capacity
//
// Reserve, errors and unused kind load the result straight from the queue head;
// release and query of a busy slot pass through B_READ for the registered read of the owner RAM.
// A 2-word command queue lets the front keep taking words while a result
// waits in the output register. Reset clears the busy map and count at once;
// the owner RAM is never cleared, busy bits mark which entries hold an id.
// A capacity write does the same clear.
module first_free_slot_owner_table_core
	import ffsot_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [CAP_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [CID_W-1:0]   client_id,
	input  wire logic [SEAT_W-1:0]  seat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [SEAT_W-1:0]       seat_number,
	output logic [CID_W-1:0]        owner_id,
	output logic [COUNT_W-1:0]      free_count,
	output logic [COUNT_W-1:0]      occupied_count
);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] usable;
	cmd_t             front_cmd;
	cmd_t             head_cmd;
	logic             q_not_full;
	logic             q_not_empty;
	logic             q_pop;

	// capacity register; the usable count derived from it saturates to the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(64);
		end else if (cfg_write) begin
			cap_q <= cfg_data;
		end
	end

	assign usable   = (CMP_W'(cap_q) > CMP_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(cap_q);
	assign in_ready = q_not_full;

	// front: range and id checks
	ffsot_front u_front (
		.kind     (kind),
		.client_id(client_id),
		.seat     (seat),
		.usable   (usable),
		.cmd      (front_cmd)
	);

	ffsot_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_cmd (front_cmd),
		.not_full (q_not_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (head_cmd)
	);

	// back: busy map, slot search, owner RAM, result register
	ffsot_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (cfg_write),
		.usable        (usable),
		.cmd_valid     (q_not_empty),
		.cmd           (head_cmd),
		.cmd_pop       (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.seat_number   (seat_number),
		.owner_id      (owner_id),
		.free_count    (free_count),
		.occupied_count(occupied_count)
	);

endmodule
`default_nettype wire

>>> rtl/ffsot_ram.sv
`default_nettype none
module ffsot_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/ffsot_front.sv
`default_nettype none
module ffsot_front
	import ffsot_pkg::*;
(
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [CID_W-1:0]  client_id,
	input  wire logic [SEAT_W-1:0] seat,
	input  wire logic [CNT_W-1:0]  usable,
	output cmd_t                   cmd
);

	logic [ID_W-1:0] id;
	logic            seat_bad;

	assign id       = client_id[ID_W-1:0];
	assign seat_bad = (seat == '0) || (CMP_W'(seat) > CMP_W'(usable));

	// classify: everything decidable without the busy map
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.status = ST_OK;
		cmd.id     = id;
		cmd.idx    = IDX_W'(seat - SEAT_W'(1));
		unique case (kind)
			KIND_RESERVE: begin
				if (id == '0) begin
					cmd.status = ST_ID_ZERO;
				end else begin
					cmd.op = OP_RESERVE;
				end
			end
			KIND_RELEASE, KIND_QUERY: begin
				if (seat_bad) begin
					cmd.status = ST_RANGE;
				end else if (kind == KIND_RELEASE) begin
					cmd.op = OP_RELEASE;
				end else begin
					cmd.op = OP_QUERY;
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/ffsot_queue.sv
`default_nettype none
module ffsot_queue
	import ffsot_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      not_full,
	input  wire logic pop,
	output logic      not_empty,
	output cmd_t      head
);

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_full  = (cnt_q != QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && not_full) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && not_full) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push && not_full, pop && not_empty})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/ffsot_back.sv
`default_nettype none
module ffsot_back
	import ffsot_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clear,
	input  wire logic [CNT_W-1:0]   usable,
	input  wire logic               cmd_valid,
	input  cmd_t                    cmd,
	output logic                    cmd_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [SEAT_W-1:0]       seat_number,
	output logic [CID_W-1:0]        owner_id,
	output logic [COUNT_W-1:0]      free_count,
	output logic [COUNT_W-1:0]      occupied_count
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_READ = 2'b10
	} bstate_t;

	bstate_t          state_q;
	logic [SLOTS-1:0] busy_q;
	logic [CNT_W-1:0] taken_q;
	logic             out_valid_q;

	logic             out_free;
	logic [SLOTS-1:0] free_vec;
	logic             found;
	logic [IDX_W-1:0] found_idx;
	logic             busy_set, busy_clr, take_inc, take_dec;
	logic             ram_we, ram_re, go_read;
	status_t          r_status;
	logic [SEAT_W-1:0] r_seat;
	logic [CNT_W-1:0] taken_next;
	logic [ID_W-1:0]  ram_rdata;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_pop   = (state_q == B_IDLE) && cmd_valid && out_free;
	assign out_valid = out_valid_q;

	// lowest free slot below the usable capacity
	always_comb begin
		free_vec  = '0;
		found     = 1'b0;
		found_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i] = !busy_q[i] && (CNT_W'(i) < usable);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		busy_set = 1'b0;
		busy_clr = 1'b0;
		take_inc = 1'b0;
		take_dec = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		go_read  = 1'b0;
		r_status = cmd.status;
		r_seat   = '0;
		unique case (cmd.op)
			OP_RESERVE: begin
				if (found) begin
					busy_set = 1'b1;
					take_inc = 1'b1;
					ram_we   = 1'b1;
					r_status = ST_OK;
					r_seat   = SEAT_W'(found_idx) + SEAT_W'(1);
				end else begin
					r_status = ST_NO_FREE;
				end
			end
			OP_RELEASE: begin
				if (busy_q[cmd.idx]) begin
					busy_clr = 1'b1;
					take_dec = 1'b1;
					ram_re   = 1'b1;
					go_read  = 1'b1;
				end else begin
					r_status = ST_ALR_FREE;
				end
			end
			OP_QUERY: begin
				// a free slot answers owner 0 without a read
				if (busy_q[cmd.idx]) begin
					ram_re  = 1'b1;
					go_read = 1'b1;
				end
			end
			default: begin
				r_status = cmd.status;
			end
		endcase
	end

	always_comb begin
		taken_next = taken_q;
		if (cmd_pop && take_inc) begin
			taken_next = taken_q + CNT_W'(1);
		end else if (cmd_pop && take_dec) begin
			taken_next = taken_q - CNT_W'(1);
		end
	end

	ffsot_ram #(
		.WIDTH(ID_W),
		.DEPTH(SLOTS)
	) u_owner_ram (
		.clk  (clk),
		.we   (cmd_pop && ram_we),
		.waddr(found_idx),
		.wdata(cmd.id),
		.re   (cmd_pop && ram_re),
		.raddr(cmd.idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			busy_q      <= '0;
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (clear) begin
			busy_q  <= '0;
			taken_q <= '0;
		end else begin
			taken_q <= taken_next;
			if (cmd_pop && busy_set) begin
				busy_q[found_idx] <= 1'b1;
			end
			if (cmd_pop && busy_clr) begin
				busy_q[cmd.idx] <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_pop && go_read) begin
						state_q <= B_READ;
					end
					if (cmd_pop && !go_read) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				B_READ: begin
					if (out_free) begin
						state_q     <= B_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd_pop && !go_read) begin
			status         <= r_status;
			seat_number    <= r_seat;
			owner_id       <= '0;
			free_count     <= COUNT_W'(usable - taken_next);
			occupied_count <= COUNT_W'(taken_next);
		end else if (state_q == B_READ && out_free) begin
			status         <= ST_OK;
			seat_number    <= '0;
			owner_id       <= CID_W'(ram_rdata);
			free_count     <= COUNT_W'(usable - taken_q);
			occupied_count <= COUNT_W'(taken_q);
		end
	end

endmodule
`default_nettype wire

>>> verif/first_free_slot_owner_table_core_tb.sv
module first_free_slot_owner_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffsot_pkg::*;

	// kind 3 has no operation; the block answers it with the current counts
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// generous: well above what the slowest phases need
	localparam int unsigned CYCLE_LIMIT = 300000;
	// cycles the receiver holds off in one stretch; far longer than the
	// 2-word command queue plus the output register can absorb
	localparam int unsigned LONG_HOLD = 80;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [CID_W-1:0]  cid;
		logic [SEAT_W-1:0] seat;
	} req_word_t;

	typedef struct {
		status_t            status;
		logic [SEAT_W-1:0]  seat_number;
		logic [CID_W-1:0]   owner_id;
		logic [COUNT_W-1:0] free_count;
		logic [COUNT_W-1:0] occupied_count;
	} slot_result_t;

	// block ports; the inputs driven here are known from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_write = 1'b0;
	logic [CAP_W-1:0]   cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind      = '0;
	logic [CID_W-1:0]   client_id = '0;
	logic [SEAT_W-1:0]  seat      = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [SEAT_W-1:0]  seat_number;
	logic [CID_W-1:0]   owner_id;
	logic [COUNT_W-1:0] free_count;
	logic [COUNT_W-1:0] occupied_count;

	// shadow of the slot table, updated as words are accepted
	logic [CAP_W-1:0] cap_reg = 7'd64;
	logic [SLOTS-1:0] seat_busy = '0;
	logic [ID_W-1:0]  held_id [SLOTS];
	int unsigned      seats_taken = 0;

	// request words waiting to be offered, results waiting to come back
	req_word_t    request_words [$];
	slot_result_t pending_results [$];

	int unsigned words_queued   = 0;
	int unsigned words_taken    = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// idle rates in percent, changed between phases
	int unsigned send_idle_pct = 22;
	int unsigned recv_idle_pct = 78;

	bit          in_taken       = 1'b0;
	bit          long_hold_req  = 1'b0;
	bit          long_hold_done = 1'b0;
	int unsigned hold_left      = 0;

	req_word_t    drv_word;
	req_word_t    seen_word;
	slot_result_t want;
	int unsigned  rand_cap;

	first_free_slot_owner_table_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.client_id      (client_id),
		.seat           (seat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.seat_number    (seat_number),
		.owner_id       (owner_id),
		.free_count     (free_count),
		.occupied_count (occupied_count)
	);

	initial forever #1 clk = ~clk;

	// One request through the shadow table. Usable slots are the capacity
	// clipped to SLOTS; a zero id is rejected before the free-slot search.
	function automatic slot_result_t slot_table_step(req_word_t w);
		slot_result_t r;
		int unsigned  lim;
		int unsigned  k;
		logic [ID_W-1:0] id;
		lim = (cap_reg > SLOTS) ? SLOTS : cap_reg;
		id = w.cid[ID_W-1:0];
		r.status = ST_OK;
		r.seat_number = '0;
		r.owner_id = '0;
		case (w.kind)
			KIND_RESERVE: begin
				if (id == '0) begin
					r.status = ST_ID_ZERO;
				end else begin
					r.status = ST_NO_FREE;
					for (k = 0; k < lim; k++) begin
						if (!seat_busy[k]) begin
							seat_busy[k] = 1'b1;
							held_id[k] = id;
							seats_taken++;
							r.seat_number = SEAT_W'(k + 1);
							r.status = ST_OK;
							break;
						end
					end
				end
			end
			KIND_RELEASE, KIND_QUERY: begin
				if (w.seat < 1 || w.seat > lim) begin
					r.status = ST_RANGE;
				end else begin
					k = w.seat - 1;
					if (w.kind == KIND_QUERY) begin
						r.owner_id = seat_busy[k] ? held_id[k] : '0;
					end else if (!seat_busy[k]) begin
						r.status = ST_ALR_FREE;
					end else begin
						r.owner_id = held_id[k];
						held_id[k] = '0;
						seat_busy[k] = 1'b0;
						if (seats_taken > 0)
							seats_taken--;
					end
				end
			end
			default: ;  // unused kind: no change
		endcase
		r.free_count = COUNT_W'((lim >= seats_taken) ? lim - seats_taken : 0);
		r.occupied_count = COUNT_W'(seats_taken);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got);
		if (got !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got);
			mismatch_count++;
		end
	endtask

	task automatic queue_word(logic [KIND_W-1:0] k, logic [CID_W-1:0] c,
			logic [SEAT_W-1:0] s);
		req_word_t w;
		w.kind = k;
		w.cid = c;
		w.seat = s;
		request_words.push_back(w);
		words_queued++;
	endtask

	// Mostly reserves and in-range releases so the table fills and drains;
	// a few zero ids, wild seats and unused kinds mixed in.
	task automatic queue_random(int unsigned n, int unsigned lim);
		int unsigned roll;
		logic [KIND_W-1:0] k;
		logic [CID_W-1:0]  c;
		logic [SEAT_W-1:0] s;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 45)
				k = KIND_RESERVE;
			else if (roll < 80)
				k = KIND_RELEASE;
			else if (roll < 96)
				k = KIND_QUERY;
			else
				k = KIND_UNUSED;
			c = CID_W'($urandom);
			if ($urandom_range(31) == 0)
				c = '0;
			if (lim == 0 || $urandom_range(15) == 0)
				s = SEAT_W'($urandom_range(127));
			else
				s = SEAT_W'($urandom_range(lim, 1));
			queue_word(k, c, s);
		end
	endtask

	// Wait until every queued word has been taken and answered. Every word
	// gets exactly one result, and a short idle margin follows.
	task automatic drain();
		while (words_taken != words_queued || pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Capacity write only with the block idle; it also clears the table.
	task automatic write_capacity(logic [CAP_W-1:0] val);
		drain();
		cfg_data  <= val;
		cfg_write <= 1'b1;
		cap_reg = val;
		seat_busy = '0;
		foreach (held_id[i])
			held_id[i] = '0;
		seats_taken = 0;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Sender: a new word goes up only when the bus is free or the last one
	// was taken at the preceding rising edge; valid holds until then.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_word = request_words.pop_front();
				in_valid  <= 1'b1;
				kind      <= drv_word.kind;
				client_id <= drv_word.cid;
				seat      <= drv_word.seat;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so the
	// command queue fills and in_ready drops.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: both handshakes sampled at the rising edge. Results are
	// checked before this edge's request is predicted; a result can never
	// belong to a word taken at the same edge.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: status %0d seat %0d owner %0h",
					status, seat_number, owner_id);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("seat_number", want.seat_number, seat_number);
				check_field("owner_id", want.owner_id, owner_id);
				check_field("free_count", want.free_count, free_count);
				check_field("occupied_count", want.occupied_count, occupied_count);
			end
		end
		if (in_taken) begin
			seen_word.kind = kind;
			seen_word.cid  = client_id;
			seen_word.seat = seat;
			pending_results.push_back(slot_table_step(seen_word));
			words_taken++;
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL first_free_slot_owner_table_core");
		$finish;
	end

	initial begin
		foreach (held_id[i])
			held_id[i] = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Reset capacity of 64: ids at both extremes, zero id, lowest free
		// slot reuse, query of a free slot, release of a free slot, seats
		// outside the range and the unused kind.
		queue_word(KIND_RESERVE, 16'hFFFF, 7'd0);
		queue_word(KIND_RESERVE, 16'h0000, 7'd5);
		queue_word(KIND_RESERVE, 16'h0001, 7'd0);
		queue_word(KIND_QUERY,   16'h0000, 7'd1);
		queue_word(KIND_QUERY,   16'h0000, 7'd3);
		queue_word(KIND_RELEASE, 16'h0000, 7'd3);
		queue_word(KIND_RELEASE, 16'h0000, 7'd1);
		queue_word(KIND_RESERVE, 16'h8000, 7'd0);
		queue_word(KIND_QUERY,   16'h0000, 7'd0);
		queue_word(KIND_QUERY,   16'h0000, 7'd64);
		queue_word(KIND_RELEASE, 16'h0000, 7'd65);
		queue_word(KIND_QUERY,   16'hFFFF, 7'd127);
		queue_word(KIND_UNUSED,  16'hA5A5, 7'd2);
		queue_word(KIND_RELEASE, 16'h0000, 7'd2);
		queue_word(KIND_RELEASE, 16'h0000, 7'd1);

		// capacity zero: nothing usable, but the zero id check still wins
		write_capacity(7'd0);
		queue_word(KIND_RESERVE, 16'h1234, 7'd0);
		queue_word(KIND_RESERVE, 16'h0000, 7'd0);
		queue_word(KIND_QUERY,   16'h0000, 7'd1);
		queue_word(KIND_RELEASE, 16'h0000, 7'd0);

		// one slot: second reserve finds the table full
		write_capacity(7'd1);
		queue_word(KIND_RESERVE, 16'h00FF, 7'd0);
		queue_word(KIND_RESERVE, 16'h0F0F, 7'd0);
		queue_word(KIND_RELEASE, 16'h0000, 7'd1);

		// all-ones capacity saturates to SLOTS
		write_capacity(7'd127);
		queue_word(KIND_QUERY,   16'h0000, 7'd64);
		queue_word(KIND_RESERVE, 16'h5A5A, 7'd0);
		queue_word(KIND_RELEASE, 16'h0000, 7'd64);
		queue_word(KIND_QUERY,   16'h0000, 7'd65);
		queue_word(KIND_RESERVE, 16'hFFFE, 7'd0);

		// random phases; sender mostly busy, receiver mostly stalled
		write_capacity(7'd5);
		queue_random(200, 5);
		write_capacity(7'd64);
		queue_random(250, 64);

		// roles swapped
		write_capacity(7'd1);
		send_idle_pct = 78;
		recv_idle_pct = 22;
		queue_random(100, 1);
		write_capacity(7'd16);
		queue_random(250, 16);

		// no idling at all, with one long receiver hold-off
		write_capacity(7'd100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_req = 1'b1;
		queue_random(250, SLOTS);
		rand_cap = $urandom_range(63, 2);
		write_capacity(CAP_W'(rand_cap));
		queue_random(250, rand_cap);

		drain();
		if (mismatch_count == 0) begin
			$display("PASS first_free_slot_owner_table_core");
		end else begin
			$display("FAIL first_free_slot_owner_table_core");
		end
		$finish;
	end

endmodule
